/* rtl/lut3d_interpolator_macros.svh */
// Assertion macros shared by the lut3d_interpolator RTL.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef LUT3D_INTERPOLATOR_MACROS_SVH
`define LUT3D_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LUT3D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LUT3D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lut3d_pkg.sv */
// Shared types and constants for the 3D LUT interpolator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lut3d_pkg;

	localparam int MAX_GRID_DEF = 33;
	localparam int CW           = 7;   // cell index / node coordinate width
	localparam int FW           = 17;  // fraction width, 0..65536
	localparam int EW           = 20;  // node channel width, signed Q3.16
	localparam int QDEPTH       = 4;   // front-to-back queue depth

	localparam logic [FW-1:0] FRAC_ONE = 17'h10000;

	// Tetrahedron: order in which the axes are walked from corner 000 to 111.
	typedef enum logic [2:0] {
		TET_RGB,
		TET_RBG,
		TET_BRG,
		TET_BGR,
		TET_GBR,
		TET_GRB
	} tetra_t;

	typedef enum logic [1:0] {
		REG_MODE,
		REG_GRID_R,
		REG_GRID_G,
		REG_GRID_B
	} reg_idx_t;

	// One queued work item: a node load or a located pixel.
	typedef struct packed {
		logic          load;
		logic [CW-1:0] r;
		logic [CW-1:0] g;
		logic [CW-1:0] b;
		logic [FW-1:0] fr;
		logic [FW-1:0] fg;
		logic [FW-1:0] fb;
		tetra_t        tet;
		logic [EW-1:0] er;
		logic [EW-1:0] eg;
		logic [EW-1:0] eb;
	} item_t;

endpackage

/* rtl/lut3d_front.sv */
// Front end: clamps and scales pixel channels to cell index and fraction,
// picks the tetrahedron, and filters node loads. Depends on lut3d_pkg.
`timescale 1ns / 1ps

module lut3d_front #(
	parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
	input  logic                func,
	input  logic signed [17:0]  pix_red,
	input  logic signed [17:0]  pix_green,
	input  logic signed [17:0]  pix_blue,
	input  logic [5:0]          node_red,
	input  logic [5:0]          node_green,
	input  logic [5:0]          node_blue,
	input  logic [19:0]         entry_red,
	input  logic [19:0]         entry_green,
	input  logic [19:0]         entry_blue,
	input  logic [5:0]          grid_red,
	input  logic [5:0]          grid_green,
	input  logic [5:0]          grid_blue,
	output lut3d_pkg::item_t    item,
	output logic                keep
);

	localparam int CW = lut3d_pkg::CW;
	localparam int FW = lut3d_pkg::FW;
	localparam logic [CW-1:0] MAX_GRID_C = CW'(MAX_GRID);

	typedef struct packed {
		logic [CW-1:0] idx;
		logic [FW-1:0] frac;
	} loc_t;

	function automatic logic [CW-1:0] size_m1(input logic [5:0] g);
		logic [CW-1:0] gz;
		gz = CW'(g);
		if (gz < CW'(2)) gz = CW'(2);
		else if (gz > MAX_GRID_C) gz = MAX_GRID_C;
		return gz - CW'(1);
	endfunction

	function automatic loc_t locate(input logic signed [17:0] x, input logic [CW-1:0] szm1);
		logic [FW-1:0]    cx;
		logic [FW+CW-1:0] pos;
		logic [CW:0]      ir;
		loc_t             l;
		if (x < 18'sd0) cx = '0;
		else if (x > 18'sd65536) cx = lut3d_pkg::FRAC_ONE;
		else cx = x[FW-1:0];
		pos = (FW+CW)'(cx) * (FW+CW)'(szm1);
		ir  = pos[FW+CW-1:16];
		// top edge: fall back to the last cell with a full fraction
		if (ir >= (CW+1)'(szm1)) begin
			l.idx  = szm1 - CW'(1);
			l.frac = lut3d_pkg::FRAC_ONE;
		end else begin
			l.idx  = ir[CW-1:0];
			l.frac = {1'b0, pos[15:0]};
		end
		return l;
	endfunction

	loc_t             loc_r, loc_g, loc_b;
	lut3d_pkg::tetra_t tet;
	logic             in_store;

	always_comb begin
		loc_r = locate(pix_red,   size_m1(grid_red));
		loc_g = locate(pix_green, size_m1(grid_green));
		loc_b = locate(pix_blue,  size_m1(grid_blue));
	end

	always_comb begin
		if (loc_r.frac > loc_g.frac) begin
			if (loc_g.frac > loc_b.frac) tet = lut3d_pkg::TET_RGB;
			else if (loc_r.frac > loc_b.frac) tet = lut3d_pkg::TET_RBG;
			else tet = lut3d_pkg::TET_BRG;
		end else begin
			if (loc_b.frac > loc_g.frac) tet = lut3d_pkg::TET_BGR;
			else if (loc_b.frac > loc_r.frac) tet = lut3d_pkg::TET_GBR;
			else tet = lut3d_pkg::TET_GRB;
		end
	end

	assign in_store = (CW'(node_red) < MAX_GRID_C) && (CW'(node_green) < MAX_GRID_C)
		&& (CW'(node_blue) < MAX_GRID_C);

	// drop loads that land outside the store
	assign keep = func || in_store;

	always_comb begin
		item.load = !func;
		item.r    = func ? loc_r.idx : CW'(node_red);
		item.g    = func ? loc_g.idx : CW'(node_green);
		item.b    = func ? loc_b.idx : CW'(node_blue);
		item.fr   = loc_r.frac;
		item.fg   = loc_g.frac;
		item.fb   = loc_b.frac;
		item.tet  = tet;
		item.er   = entry_red;
		item.eg   = entry_green;
		item.eb   = entry_blue;
	end

endmodule

/* rtl/lut3d_queue.sv */
// Short queue between front and back end; lets either side stall alone.
// Depends on lut3d_pkg and lut3d_interpolator_macros.svh.
`timescale 1ns / 1ps
`include "lut3d_interpolator_macros.svh"

module lut3d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lut3d_pkg::item_t din,
	input  logic             pop,
	output lut3d_pkg::item_t head,
	output logic             head_valid,
	output logic             full
);

	localparam int DEPTH = lut3d_pkg::QDEPTH;
	localparam int PTRW  = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	lut3d_pkg::item_t  slots_q [DEPTH];
	logic [PTRW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]   count_q;

	assign head       = slots_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign full       = count_q == CNTW'(DEPTH);

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTRW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTRW'(1);
			if (push && !pop) count_q <= count_q + CNTW'(1);
			else if (pop && !push) count_q <= count_q - CNTW'(1);
		end
	end

	`LUT3D_ASSERT_IMP(a_pop_nonempty, pop, head_valid, "pop from empty queue")
	`LUT3D_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
	`LUT3D_ASSERT_NEXT(a_push_counts, push && !pop, count_q == $past(count_q) + CNTW'(1), "push lost")

endmodule

/* rtl/lut3d_back.sv */
// Back end: eight parity banks of node storage, corner fetch and the
// trilinear / tetrahedral blend pipeline with output register.
// Depends on lut3d_pkg and lut3d_interpolator_macros.svh.
`timescale 1ns / 1ps
`include "lut3d_interpolator_macros.svh"

module lut3d_back #(
	parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mode,
	input  logic             head_valid,
	input  lut3d_pkg::item_t head,
	output logic             pop,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [59:0]      res
);

	localparam int CW   = lut3d_pkg::CW;
	localparam int FW   = lut3d_pkg::FW;
	localparam int HALF = (MAX_GRID + 1) / 2;
	localparam int HW   = (HALF > 1) ? $clog2(HALF) : 1;
	localparam int BD   = HALF * HALF * HALF;
	localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
	localparam logic [AW-1:0] HALF_A = AW'(HALF);
	localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
	localparam logic signed [19:0] OUT_MIN = 20'sh80000;

	function automatic logic [HW-1:0] half_coord(input logic [CW-1:0] x, input logic p);
		return HW'(x >> 1) + HW'(x[0] & ~p);
	endfunction

	function automatic logic [AW-1:0] bank_addr(input logic [HW-1:0] cr, input logic [HW-1:0] cg,
		input logic [HW-1:0] cb);
		return AW'(cr) + HALF_A * (AW'(cg) + HALF_A * AW'(cb));
	endfunction

	// a + (b - a) * f, rounded to nearest with ties up
	function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
		input logic signed [19:0] b, input logic [FW-1:0] f);
		logic signed [20:0] d;
		logic signed [17:0] fs;
		logic signed [38:0] acc;
		d   = 21'(b) - 21'(a);
		fs  = $signed({1'b0, f});
		acc = (39'(a) <<< 16) + 39'(d) * 39'(fs) + 39'sd32768;
		return 20'(acc >>> 16);
	endfunction

	function automatic logic signed [19:0] sat20(input logic signed [24:0] v);
		if (v > 25'(OUT_MAX)) return OUT_MAX;
		if (v < 25'(OUT_MIN)) return OUT_MIN;
		return 20'(v);
	endfunction

	logic adv;
	logic v_s2, v_s3, v_s4, out_valid_q;

	// the whole back end advances together unless the result is held
	assign adv      = !out_valid_q || m_tready;
	assign pop      = adv && head_valid;
	assign m_tvalid = out_valid_q;

	// ---- stage 1: bank access ----
	logic [7:0]      we_v;
	logic [AW-1:0]   wa;
	logic [59:0]     wdata;
	logic [59:0]     rd_s2 [8];

	assign wa    = bank_addr(half_coord(head.r, 1'b1), half_coord(head.g, 1'b1),
		half_coord(head.b, 1'b1));
	assign wdata = {head.eb, head.eg, head.er};

	for (genvar k = 0; k < 8; k++) begin : g_bank
		localparam logic [2:0] KB = 3'(k);
		logic [59:0]   mem [BD];
		logic [59:0]   rd_q;
		logic [AW-1:0] ra;

		assign ra = bank_addr(half_coord(head.r, KB[2]), half_coord(head.g, KB[1]),
			half_coord(head.b, KB[0]));
		assign we_v[k] = pop && head.load && ({head.r[0], head.g[0], head.b[0]} == KB);

		always_ff @(posedge clk) begin
			if (we_v[k]) mem[wa] <= wdata;
			if (adv) rd_q <= mem[ra];
		end

		assign rd_s2[k] = rd_q;
	end

	logic              mode_s2;
	lut3d_pkg::tetra_t tet_s2;
	logic [FW-1:0]     fr_s2, fg_s2, fb_s2;
	logic [2:0]        par_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode;
			tet_s2  <= head.tet;
			fr_s2   <= head.fr;
			fg_s2   <= head.fg;
			fb_s2   <= head.fb;
			par_s2  <= {head.r[0], head.g[0], head.b[0]};
		end
	end

	// ---- stage 2: corners, first lerp level, tetra products ----
	logic signed [19:0] vc [3][8];
	logic [2:0]         sel_a, sel_b;
	logic [FW-1:0]      fa, fbb, fc;
	logic signed [19:0] e_c [3][4];
	logic signed [38:0] p_c [3][3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			for (int k = 0; k < 8; k++)
				vc[c][k] = $signed(rd_s2[3'(k) ^ par_s2][20*c +: 20]);
	end

	always_comb begin
		unique case (tet_s2)
			lut3d_pkg::TET_RGB: begin
				sel_a = 3'b100; sel_b = 3'b110; fa = fr_s2; fbb = fg_s2; fc = fb_s2;
			end
			lut3d_pkg::TET_RBG: begin
				sel_a = 3'b100; sel_b = 3'b101; fa = fr_s2; fbb = fb_s2; fc = fg_s2;
			end
			lut3d_pkg::TET_BRG: begin
				sel_a = 3'b001; sel_b = 3'b101; fa = fb_s2; fbb = fr_s2; fc = fg_s2;
			end
			lut3d_pkg::TET_BGR: begin
				sel_a = 3'b001; sel_b = 3'b011; fa = fb_s2; fbb = fg_s2; fc = fr_s2;
			end
			lut3d_pkg::TET_GBR: begin
				sel_a = 3'b010; sel_b = 3'b011; fa = fg_s2; fbb = fb_s2; fc = fr_s2;
			end
			lut3d_pkg::TET_GRB: begin
				sel_a = 3'b010; sel_b = 3'b110; fa = fg_s2; fbb = fr_s2; fc = fb_s2;
			end
			default: begin
				sel_a = 3'b100; sel_b = 3'b110; fa = fr_s2; fbb = fg_s2; fc = fb_s2;
			end
		endcase
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int j = 0; j < 4; j++)
				e_c[c][j] = lerp(vc[c][j], vc[c][4+j], fr_s2);
			p_c[c][0] = 39'(21'(vc[c][sel_a]) - 21'(vc[c][0])) * 39'($signed({1'b0, fa}));
			p_c[c][1] = 39'(21'(vc[c][sel_b]) - 21'(vc[c][sel_a])) * 39'($signed({1'b0, fbb}));
			p_c[c][2] = 39'(21'(vc[c][7]) - 21'(vc[c][sel_b])) * 39'($signed({1'b0, fc}));
		end
	end

	logic signed [19:0] e_s3 [3][4];
	logic signed [38:0] p_s3 [3][3];
	logic signed [19:0] base_s3 [3];
	logic [FW-1:0]      fg_s3, fb_s3;
	logic               mode_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s3    <= e_c;
			p_s3    <= p_c;
			for (int c = 0; c < 3; c++) base_s3[c] <= vc[c][0];
			fg_s3   <= fg_s2;
			fb_s3   <= fb_s2;
			mode_s3 <= mode_s2;
		end
	end

	// ---- stage 3: second lerp level, tetra sum and round ----
	logic signed [19:0] f_c [3][2];
	logic signed [24:0] t_c [3];
	logic signed [40:0] acc_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int j = 0; j < 2; j++)
				f_c[c][j] = lerp(e_s3[c][j], e_s3[c][2+j], fg_s3);
			acc_c[c] = (41'(base_s3[c]) <<< 16) + 41'(p_s3[c][0]) + 41'(p_s3[c][1])
				+ 41'(p_s3[c][2]) + 41'sd32768;
			t_c[c] = 25'(acc_c[c] >>> 16);
		end
	end

	logic signed [19:0] f_s4 [3][2];
	logic signed [24:0] t_s4 [3];
	logic [FW-1:0]      fb_s4;
	logic               mode_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4    <= f_c;
			t_s4    <= t_c;
			fb_s4   <= fb_s3;
			mode_s4 <= mode_s3;
		end
	end

	// ---- stage 4: last lerp level, select and saturate into output ----
	logic signed [19:0] res_q [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++)
				res_q[c] <= mode_s4 ? sat20(t_s4[c]) : lerp(f_s4[c][0], f_s4[c][1], fb_s4);
		end
	end

	assign res = {res_q[2], res_q[1], res_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= head_valid && !head.load;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	`LUT3D_ASSERT_IMP(a_one_bank_wr, 1'b1, $onehot0(we_v), "more than one bank written")
	`LUT3D_ASSERT_NEXT(a_load_no_result, pop && head.load, !v_s2, "load produced a result")
	`LUT3D_ASSERT_NEXT(a_stall_holds, !adv, $stable(v_s3) && $stable(v_s4), "pipeline moved in stall")

endmodule

/* rtl/lut3d_interpolator.sv */
// 3D colour LUT with trilinear or tetrahedral interpolation, top level.
// Instantiates lut3d_front, lut3d_queue, lut3d_back; depends on lut3d_pkg.
//
// Usage:
//  - Slave stream (s_*): tuser selects the beat kind. tuser=0 loads one table
//    node (no result), tuser=1 interpolates one pixel (one result beat).
//  - Master stream (m_*): one beat per pixel, in input order.
//  - APB port: interp_mode at 0x0, grid_red 0x4, grid_green 0x8, grid_blue 0xC.
//    Write only while the block is idle. pready is tied high.
//  - Throughput: one beat per cycle while s_tready is high, loads and pixels
//    mixed freely; a load is visible to the very next pixel beat.
//  - A pixel passes from the queue to the bank read, two blend stages and
//    the output register before it shows on m_tvalid.
//  - Node storage is eight parity banks of ((MAX_GRID+1)/2)^3 words each,
//    so all eight cell corners are read in the same cycle. Contents are undefined
//    after reset until loaded; registers reset to tetrahedral, 17x17x17.
//  - When a result waits and m_tready is low the back end holds; the four-entry
//    queue keeps taking beats until full, then s_tready drops.
`timescale 1ns / 1ps

module lut3d_interpolator #(
	parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pix_red[17:0] pix_green[35:18] pix_blue[53:36] node_red[59:54]
	// node_green[65:60] node_blue[71:66] entry_red[91:72]
	// entry_green[111:92] entry_blue[131:112], zero pad [135:132]
	input  logic [135:0] s_tdata,
	// func[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_red[19:0] out_green[39:20] out_blue[59:40], zero pad [63:60]
	output logic [63:0]  m_tdata
);

	// ---- configuration registers ----
	logic       mode_q;
	logic [5:0] grid_red_q, grid_green_q, grid_blue_q;
	logic       cfg_wr;
	lut3d_pkg::reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = lut3d_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b1;
			grid_red_q   <= 6'd17;
			grid_green_q <= 6'd17;
			grid_blue_q  <= 6'd17;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				lut3d_pkg::REG_MODE:   mode_q       <= pwdata[0];
				lut3d_pkg::REG_GRID_R: grid_red_q   <= pwdata[5:0];
				lut3d_pkg::REG_GRID_G: grid_green_q <= pwdata[5:0];
				lut3d_pkg::REG_GRID_B: grid_blue_q  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lut3d_pkg::REG_MODE:   prdata = 32'(mode_q);
			lut3d_pkg::REG_GRID_R: prdata = 32'(grid_red_q);
			lut3d_pkg::REG_GRID_G: prdata = 32'(grid_green_q);
			lut3d_pkg::REG_GRID_B: prdata = 32'(grid_blue_q);
			default:               prdata = '0;
		endcase
	end

	// ---- front end: locate and classify ----
	lut3d_pkg::item_t fe_item, q_head;
	logic             fe_keep, q_full, q_head_valid, q_pop, s_accept;

	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;

	lut3d_front #(.MAX_GRID(MAX_GRID)) u_front (
		.func        (s_tuser),
		.pix_red     ($signed(s_tdata[17:0])),
		.pix_green   ($signed(s_tdata[35:18])),
		.pix_blue    ($signed(s_tdata[53:36])),
		.node_red    (s_tdata[59:54]),
		.node_green  (s_tdata[65:60]),
		.node_blue   (s_tdata[71:66]),
		.entry_red   (s_tdata[91:72]),
		.entry_green (s_tdata[111:92]),
		.entry_blue  (s_tdata[131:112]),
		.grid_red    (grid_red_q),
		.grid_green  (grid_green_q),
		.grid_blue   (grid_blue_q),
		.item        (fe_item),
		.keep        (fe_keep)
	);

	// ---- queue: decouple front from the blend pipeline ----
	lut3d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_accept && fe_keep),
		.din        (fe_item),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid),
		.full       (q_full)
	);

	// ---- back end: storage, corner fetch, blend, output register ----
	logic [59:0] res;

	lut3d_back #(.MAX_GRID(MAX_GRID)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.res        (res)
	);

	assign m_tdata = {4'b0, res};

endmodule

/* tb/sv/tb_lut3d_interpolator.sv */
// Self-checking testbench for lut3d_interpolator: node loads and pixel lookups
// over the stream ports, with register writes over APB. Depends on lut3d_pkg.
`timescale 1ns / 1ps

module tb_lut3d_interpolator;

	localparam int MG        = 33;
	localparam int LIMIT     = 400000;
	localparam int N_RANDOM  = 210;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid, s_tready, s_tuser;
	logic [135:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [63:0]  m_tdata;

	lut3d_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct {
		logic        func;
		logic [17:0] pr, pg, pb;
		logic [5:0]  nr, ng, nb;
		logic [19:0] er, eg, eb;
	} beat_t;

	typedef struct {
		logic [59:0] rgb;
		logic        fixed;   // value typed in directly
	} out_beat_t;

	// Shadow of the table and the registers
	logic signed [19:0] lut_shadow [MG*MG*MG][3];
	bit                 written [MG*MG*MG];
	logic               mode_q;
	logic [5:0]         grid_q [3];

	logic [59:0] pending_rgb [$];
	int          errors, mismatches, cycles, pixels_seen;
	int          rx_wait;
	bit          hold_long;

	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int eff_grid(logic [5:0] g);
		if (g < 2) return 2;
		if (g > MG) return MG;
		return g;
	endfunction

	function automatic longint rnd16(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint clamp20(longint v);
		if (v > 524287) return 524287;
		if (v < -524288) return -524288;
		return v;
	endfunction

	// Find cell index and fraction for one channel
	task automatic cell_of(input logic [17:0] x_raw, input int size,
			output int idx, output longint frac);
		longint x;
		longint pos;
		x = longint'($signed(x_raw));
		if (x < 0) x = 0;
		if (x > 65536) x = 65536;
		pos = x * (size - 1);
		idx = int'(pos >> 16);
		frac = pos & 16'hFFFF;
		if (idx >= size - 1) begin
			idx = size - 2;
			frac = 65536;
		end
	endtask

	function automatic longint node_val(int r, int g, int b, int c);
		return longint'(lut_shadow[r + MG*(g + MG*b)][c]);
	endfunction

	function automatic longint blend(longint a, longint b, longint f);
		return rnd16(a * (65536 - f) + b * f);
	endfunction

	// Interpolate one pixel against the shadow table
	task automatic interpolate_pixel(input beat_t bt, output logic [59:0] rgb);
		int ri, gi, bi;
		longint fr, fg, fb;
		longint v[8];
		longint acc, res;
		cell_of(bt.pr, eff_grid(grid_q[0]), ri, fr);
		cell_of(bt.pg, eff_grid(grid_q[1]), gi, fg);
		cell_of(bt.pb, eff_grid(grid_q[2]), bi, fb);
		for (int c = 0; c < 3; c++) begin
			// v index bits: {r,g,b}
			for (int k = 0; k < 8; k++)
				v[k] = node_val(ri + k[2], gi + k[1], bi + k[0], c);
			if (mode_q == 1'b0) begin
				res = blend(blend(blend(v[0], v[4], fr), blend(v[2], v[6], fr), fg),
					blend(blend(v[1], v[5], fr), blend(v[3], v[7], fr), fg), fb);
			end else begin
				acc = v[0] * 65536;
				if (fr > fg) begin
					if (fg > fb)
						acc += (v[4]-v[0])*fr + (v[6]-v[4])*fg + (v[7]-v[6])*fb;
					else if (fr > fb)
						acc += (v[4]-v[0])*fr + (v[5]-v[4])*fb + (v[7]-v[5])*fg;
					else
						acc += (v[1]-v[0])*fb + (v[5]-v[1])*fr + (v[7]-v[5])*fg;
				end else begin
					if (fb > fg)
						acc += (v[1]-v[0])*fb + (v[3]-v[1])*fg + (v[7]-v[3])*fr;
					else if (fb > fr)
						acc += (v[2]-v[0])*fg + (v[3]-v[2])*fb + (v[7]-v[3])*fr;
					else
						acc += (v[2]-v[0])*fg + (v[6]-v[2])*fr + (v[7]-v[6])*fb;
				end
				res = rnd16(acc);
			end
			rgb[20*c +: 20] = 20'(clamp20(res));
		end
	endtask

	// Update shadow for one accepted beat and queue any expected result
	task automatic model_beat(input beat_t bt, input logic [59:0] typed, input bit use_typed);
		logic [59:0] rgb;
		int a;
		if (!bt.func) begin
			if (bt.nr < MG && bt.ng < MG && bt.nb < MG) begin
				a = bt.nr + MG*(bt.ng + MG*bt.nb);
				lut_shadow[a][0] = bt.er;
				lut_shadow[a][1] = bt.eg;
				lut_shadow[a][2] = bt.eb;
				written[a] = 1'b1;
			end
		end else begin
			interpolate_pixel(bt, rgb);
			if (use_typed && rgb != typed) begin
				errors++;
				$display("Directed row disagrees with predictor: typed %h predicted %h",
					typed, rgb);
			end
			pending_rgb.push_back(use_typed ? typed : rgb);
		end
	endtask

	// Send one beat: random gap, then hold valid until accepted.
	// Valid stays high after the beat so the next one can follow back to back.
	task automatic send_beat(input beat_t bt, input logic [59:0] typed, input bit use_typed);
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= bt.func;
		s_tdata  <= {4'b0, bt.eb, bt.eg, bt.er, bt.nb, bt.ng, bt.nr, bt.pb, bt.pg, bt.pr};
		do @(posedge clk); while (!s_tready);
		// accepted at this edge
		model_beat(bt, typed, use_typed);
	endtask

	task automatic apb_write(input lut3d_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 4'(int'(idx) * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			lut3d_pkg::REG_MODE:   mode_q    = val[0];
			lut3d_pkg::REG_GRID_R: grid_q[0] = val[5:0];
			lut3d_pkg::REG_GRID_G: grid_q[1] = val[5:0];
			lut3d_pkg::REG_GRID_B: grid_q[2] = val[5:0];
			default: ;
		endcase
	endtask

	// Drop valid, wait for the result queue to drain, then let the pipeline settle
	task automatic drain_all();
		s_tvalid <= 1'b0;
		while (pending_rgb.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Receiver: a random idle wait after each accepted beat, plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				pixels_seen++;
				if (pending_rgb.size() == 0) begin
					errors++;
					if (mismatches < 10) $display("Unexpected result beat %h", m_tdata);
					mismatches++;
				end else begin
					if (m_tdata[59:0] !== pending_rgb[0] || m_tdata[63:60] !== 4'b0) begin
						errors++;
						if (mismatches < 10)
							$display("Mismatch: expected r=%h g=%h b=%h got r=%h g=%h b=%h",
								pending_rgb[0][19:0], pending_rgb[0][39:20],
								pending_rgb[0][59:40], m_tdata[19:0], m_tdata[39:20],
								m_tdata[59:40]);
						mismatches++;
					end
					void'(pending_rgb.pop_front());
				end
				rx_wait = $urandom_range(0, 3);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= hold_long ? 1'b0 : (rx_wait == 0);
		end
	end

	// Hold the receiver off for a long stretch
	task automatic long_hold();
		hold_long = 1'b1;
		repeat (60) @(posedge clk);
		hold_long = 1'b0;
	endtask

	function automatic beat_t load_beat(int r, int g, int b, logic [19:0] er,
			logic [19:0] eg, logic [19:0] eb);
		beat_t bt;
		bt = '{default: '0};
		bt.func = 1'b0;
		bt.nr = 6'(r); bt.ng = 6'(g); bt.nb = 6'(b);
		bt.er = er; bt.eg = eg; bt.eb = eb;
		bt.pr = 18'($urandom); bt.pg = 18'($urandom); bt.pb = 18'($urandom);
		return bt;
	endfunction

	function automatic beat_t pixel_beat(logic [17:0] r, logic [17:0] g, logic [17:0] b);
		beat_t bt;
		bt = '{default: '0};
		bt.func = 1'b1;
		bt.pr = r; bt.pg = g; bt.pb = b;
		bt.nr = 6'($urandom); bt.ng = 6'($urandom); bt.nb = 6'($urandom);
		bt.er = 20'($urandom); bt.eg = 20'($urandom); bt.eb = 20'($urandom);
		return bt;
	endfunction

	// Load every node of the active grid not yet written, so that every read is defined
	task automatic fill_grid(input int gr, input int gg, input int gb);
		for (int b = 0; b < gb; b++)
			for (int g = 0; g < gg; g++)
				for (int r = 0; r < gr; r++)
					if (!written[r + MG*(g + MG*b)])
						send_beat(load_beat(r, g, b, 20'($urandom), 20'($urandom),
							20'($urandom)), '0, 1'b0);
	endtask

	function automatic logic [17:0] rand_pix();
		case ($urandom_range(0, 5))
			0: return 18'h20000;
			1: return 18'h10000;
			2: return 18'h1FFFF;
			3: return 18'd0;
			default: return 18'($urandom);
		endcase
	endfunction

	// Directed rows: a constant table checks extreme node values at a glance
	typedef struct {
		beat_t       bt;
		logic [59:0] typed;
		bit          use_typed;
	} row_t;

	row_t rows [$];

	initial begin
		beat_t bt;
		row_t  rw;
		int    gsel [3];
		arst_n   = 1'b0;
		psel     = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
		m_tready = 1'b0;
		hold_long = 1'b0;
		errors = 0; mismatches = 0; cycles = 0; pixels_seen = 0;
		mode_q = 1'b1; grid_q[0] = 17; grid_q[1] = 17; grid_q[2] = 17;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Smallest grid, trilinear, constant table at the most positive, most negative and zero values
		apb_write(lut3d_pkg::REG_MODE, 0);
		apb_write(lut3d_pkg::REG_GRID_R, 2);
		apb_write(lut3d_pkg::REG_GRID_G, 2);
		apb_write(lut3d_pkg::REG_GRID_B, 2);
		for (int k = 0; k < 8; k++) begin
			rw.bt = load_beat(k[2], k[1], k[0], 20'h7FFFF, 20'h80000, 20'h00000);
			rw.typed = '0; rw.use_typed = 1'b0; rows.push_back(rw);
		end
		// Loads outside the store are dropped
		rw.bt = load_beat(MG, 0, 0, 20'h12345, 0, 0); rows.push_back(rw);
		rw.bt = load_beat(0, 63, 0, 20'h12345, 0, 0); rows.push_back(rw);
		rw.bt = load_beat(0, 0, 40, 20'h12345, 0, 0); rows.push_back(rw);
		// Constant table: every pixel gives the node value
		rw.typed = {20'h00000, 20'h80000, 20'h7FFFF}; rw.use_typed = 1'b1;
		rw.bt = pixel_beat(18'h20000, 18'h20000, 18'h20000); rows.push_back(rw);
		rw.bt = pixel_beat(18'h1FFFF, 18'h1FFFF, 18'h1FFFF); rows.push_back(rw);
		rw.bt = pixel_beat(18'h10000, 0, 18'h08000); rows.push_back(rw);
		rw.bt = pixel_beat(18'h04000, 18'h0C000, 18'h3FFFF); rows.push_back(rw);
		foreach (rows[i]) send_beat(rows[i].bt, rows[i].typed, rows[i].use_typed);
		drain_all();

		// Same constant table in tetrahedral mode, ties and each ordering
		apb_write(lut3d_pkg::REG_MODE, 1);
		send_beat(pixel_beat(18'h10000, 18'h10000, 18'h10000),
			{20'h00000, 20'h80000, 20'h7FFFF}, 1'b1);
		// A ramp on corner 111 exercises the fraction ordering
		send_beat(load_beat(1, 1, 1, 20'h10000, 20'h3FFFF, 20'h70000), '0, 1'b0);
		send_beat(load_beat(0, 0, 0, 0, 0, 0), '0, 1'b0);
		for (int p = 0; p < 6; p++) begin
			logic [17:0] f [3];
			f[0] = 18'h04000; f[1] = 18'h08000; f[2] = 18'h0C000;
			send_beat(pixel_beat(f[p % 3], f[(p + 1 + p / 3) % 3], f[(p + 2 - p / 3) % 3]),
				'0, 1'b0);
		end
		send_beat(pixel_beat(18'h08000, 18'h08000, 18'h04000), '0, 1'b0);
		send_beat(pixel_beat(18'h04000, 18'h08000, 18'h08000), '0, 1'b0);
		drain_all();

		// Random phases: several grid settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin gsel[0] = 2;  gsel[1] = 3;  gsel[2] = 2;  end
				1: begin gsel[0] = 0;  gsel[1] = 1;  gsel[2] = 63; end
				2: begin gsel[0] = 2;  gsel[1] = 2;  gsel[2] = 34; end
				3: begin gsel[0] = 4;  gsel[1] = 5;  gsel[2] = 3;  end
				4: begin gsel[0] = 3;  gsel[1] = 2;  gsel[2] = 4;  end
				default: begin gsel[0] = 2; gsel[1] = 2; gsel[2] = 2; end
			endcase
			apb_write(lut3d_pkg::REG_MODE, ph % 2);
			apb_write(lut3d_pkg::REG_GRID_R, gsel[0]);
			apb_write(lut3d_pkg::REG_GRID_G, gsel[1]);
			apb_write(lut3d_pkg::REG_GRID_B, gsel[2]);
			fill_grid(eff_grid(gsel[0]), eff_grid(gsel[1]), eff_grid(gsel[2]));
			if (ph == 2) fork long_hold(); join_none
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					// rewrite a node inside the active grid, or noise outside the store
					if ($urandom_range(0, 5) == 0)
						bt = load_beat($urandom_range(33, 63), $urandom_range(0, 63),
							$urandom_range(0, 63), 20'($urandom), 20'($urandom),
							20'($urandom));
					else
						bt = load_beat($urandom_range(0, eff_grid(gsel[0]) - 1),
							$urandom_range(0, eff_grid(gsel[1]) - 1),
							$urandom_range(0, eff_grid(gsel[2]) - 1),
							20'($urandom), 20'($urandom), 20'($urandom));
				end else begin
					bt = pixel_beat(rand_pix(), rand_pix(), rand_pix());
				end
				send_beat(bt, '0, 1'b0);
			end
			// Pause the sender until every result is back
			drain_all();
		end

		drain_all();
		$display("Covered %0d pixel results over both modes and grid sizes 2 to 33,", pixels_seen);
		$display("with node rewrites, dropped loads and receiver back-pressure.");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
